### rtl/core/ordered_list_engine_macros.svh
// ----------------------------------------------------------------------------
// Ordered list engine assertion macros
// Clocked implication checks on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define OLE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define OLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define OLE_ASSERT_IMPL(lbl, ante, cons, msg)

`define OLE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/core/ole_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list engine package
// Field widths, operation and status codes, cell commands.
// ----------------------------------------------------------------------------
package ole_pkg;

    localparam int FUNC_W = 3;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 5;

    localparam int DEPTH_DEF = 16;
    localparam int WIDTH_DEF = 32;

    localparam logic [POS_W-1:0] FOUND_NONE = '1;

    typedef enum logic [FUNC_W-1:0] {
        FN_APPEND = 3'd0,
        FN_INSERT = 3'd1,
        FN_REMOVE = 3'd2,
        FN_READ   = 3'd3,
        FN_FIND   = 3'd4,
        FN_CLEAR  = 3'd5
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_APPEND = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_REMOVE = 2'd3
    } t_cell_op;

endpackage

### rtl/core/ole_cell.sv
// ----------------------------------------------------------------------------
// Ordered list engine cell
// Holds one list entry; loads the new value or a neighbor's entry on
// append, insert and remove, and flags a match for find.
// ----------------------------------------------------------------------------
module ole_cell #(
    parameter int WIDTH = 32,
    parameter int IDX   = 0,
    parameter int CMPW  = 5
) (
    input  logic                i_clk,
    input  ole_pkg::t_cell_op   i_op,
    input  logic [CMPW-1:0]     i_pos,
    input  logic [CMPW-1:0]     i_cnt,
    input  logic [WIDTH-1:0]    i_val,
    input  logic [WIDTH-1:0]    i_left,
    input  logic [WIDTH-1:0]    i_right,
    output logic [WIDTH-1:0]    o_entry,
    output logic                o_match
);
    import ole_pkg::*;

    localparam logic [CMPW-1:0] IDX_V  = CMPW'(IDX);
    localparam logic [CMPW-1:0] IDX_V1 = CMPW'(IDX + 1);

    logic [WIDTH-1:0] r_entry;
    logic [WIDTH-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        unique case (i_op)
            CELL_APPEND: begin
                if (IDX_V == i_cnt) n_entry = i_val;
            end
            CELL_INSERT: begin
                if (IDX_V == i_pos) begin
                    n_entry = i_val;
                end else if (IDX_V > i_pos && IDX_V <= i_cnt) begin
                    n_entry = i_left;
                end
            end
            CELL_REMOVE: begin
                if (IDX_V >= i_pos && IDX_V1 < i_cnt) n_entry = i_right;
            end
            CELL_HOLD: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_match = (r_entry == i_val) && (IDX_V < i_cnt);

endmodule

### rtl/core/ole_prio.sv
// ----------------------------------------------------------------------------
// Ordered list engine first-match encoder
// Gives the lowest cell index whose match flag is set.
// ----------------------------------------------------------------------------
module ole_prio #(
    parameter int DEPTH = 16,
    parameter int IW    = 4
) (
    input  logic [DEPTH-1:0] i_match,
    output logic             o_hit,
    output logic [IW-1:0]    o_idx
);
    always_comb begin
        o_hit = 1'b0;
        o_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (i_match[i]) begin
                o_hit = 1'b1;
                o_idx = IW'(i);
            end
        end
    end

endmodule

### rtl/core/ordered_list_engine.sv
// ----------------------------------------------------------------------------
// Ordered list engine
// Bounded ordered list held in a row of cells: append, insert, remove,
// read, find and clear, one status beat per request.
// ----------------------------------------------------------------------------
// Pipeline: stage-one registers, then output registers; one request per
//   cycle while o_stall is low. Every cell shifts or compares in the accept
//   cycle, the first-match encode runs in the second stage.
// Reset: synchronous, active low; count and valid flags clear, entries are
//   left as they are and read only after being written.
`include "ordered_list_engine_macros.svh"

module ordered_list_engine #(
    parameter int DEPTH = ole_pkg::DEPTH_DEF,
    parameter int WIDTH = ole_pkg::WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [ole_pkg::FUNC_W-1:0]  i_func,
    input  logic [ole_pkg::POS_W-1:0]   i_position,
    input  logic [ole_pkg::VAL_W-1:0]   i_in_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [ole_pkg::STAT_W-1:0]  o_status,
    output logic [ole_pkg::VAL_W-1:0]   o_out_value,
    output logic signed [ole_pkg::POS_W-1:0] o_found_position,
    output logic [ole_pkg::CNT_W-1:0]   o_entry_count
);
    import ole_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = $clog2(DEPTH);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic                in_acc;
    logic                s1_adv;
    logic [63:0]         val64;
    logic [WIDTH-1:0]    val;
    logic [CMPW-1:0]     pos_x;
    logic [CMPW-1:0]     cnt_x;
    logic                full;
    t_func               func;
    t_cell_op            cell_op;
    t_status             status;
    logic [CW-1:0]       n_count;
    logic [VAL_W-1:0]    rd_value;
    logic                is_find;

    logic [WIDTH-1:0]    entry [DEPTH];
    logic [DEPTH-1:0]    match;

    logic [CW-1:0]       r_count;

    logic                r_s1_valid;
    t_status             r_s1_status;
    logic [VAL_W-1:0]    r_s1_value;
    logic [DEPTH-1:0]    r_s1_match;
    logic                r_s1_find;
    logic [CNT_W-1:0]    r_s1_count;

    logic                r_out_valid;
    t_status             r_status;
    logic [VAL_W-1:0]    r_value;
    logic [POS_W-1:0]    r_found;
    logic [CNT_W-1:0]    r_out_count;

    logic                hit;
    logic [IW-1:0]       hit_idx;

    assign s1_adv  = !r_out_valid || !i_stall;
    assign o_stall = r_s1_valid && !s1_adv;
    assign in_acc  = i_valid && !o_stall;

    assign val64 = 64'(i_in_value);
    assign val   = val64[WIDTH-1:0];
    assign pos_x = CMPW'(i_position);
    assign cnt_x = CMPW'(r_count);
    assign full  = (r_count == CW'(DEPTH));
    assign func  = t_func'(i_func);

    always_comb begin
        logic [63:0] e64;
        rd_value = '0;
        for (int i = 0; i < DEPTH; i++) begin
            e64 = 64'(entry[i]);
            if (pos_x == CMPW'(i)) rd_value = e64[VAL_W-1:0];
        end
    end

    always_comb begin
        cell_op = CELL_HOLD;
        status  = ST_OK;
        n_count = r_count;
        is_find = 1'b0;
        unique case (func)
            FN_APPEND: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    cell_op = CELL_APPEND;
                    n_count = r_count + 1'b1;
                end
            end
            FN_INSERT: begin
                if (pos_x > cnt_x) begin
                    status = ST_RANGE;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    cell_op = CELL_INSERT;
                    n_count = r_count + 1'b1;
                end
            end
            FN_REMOVE: begin
                if (pos_x >= cnt_x) begin
                    status = ST_RANGE;
                end else begin
                    cell_op = CELL_REMOVE;
                    n_count = r_count - 1'b1;
                end
            end
            FN_READ: begin
                if (pos_x >= cnt_x) status = ST_RANGE;
            end
            FN_FIND: begin
                is_find = 1'b1;
            end
            FN_CLEAR: begin
                n_count = '0;
            end
            default: begin
                status = ST_OK;
            end
        endcase
        if (!in_acc) cell_op = CELL_HOLD;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WIDTH-1:0] left;
        logic [WIDTH-1:0] right;
        if (g == 0) begin : g_first
            assign left = '0;
        end else begin : g_mid_l
            assign left = entry[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right = '0;
        end else begin : g_mid_r
            assign right = entry[g+1];
        end
        ole_cell #(
            .WIDTH (WIDTH),
            .IDX   (g),
            .CMPW  (CMPW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (cell_op),
            .i_pos   (pos_x),
            .i_cnt   (cnt_x),
            .i_val   (val),
            .i_left  (left),
            .i_right (right),
            .o_entry (entry[g]),
            .o_match (match[g])
        );
    end

    ole_prio #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_prio (
        .i_match (r_s1_match),
        .o_hit   (hit),
        .o_idx   (hit_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) r_count <= n_count;
            if (!r_s1_valid || s1_adv) r_s1_valid <= in_acc;
            if (s1_adv) r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_status <= status;
            r_s1_value  <= (status == ST_OK && (func == FN_READ || func == FN_REMOVE)) ?
                           rd_value : '0;
            r_s1_match  <= match;
            r_s1_find   <= is_find;
            r_s1_count  <= CNT_W'(n_count);
        end
        if (s1_adv && r_s1_valid) begin
            r_value     <= r_s1_value;
            r_out_count <= r_s1_count;
            if (r_s1_find) begin
                r_status <= hit ? ST_OK : ST_NOT_FOUND;
                r_found  <= hit ? POS_W'(hit_idx) : FOUND_NONE;
            end else begin
                r_status <= r_s1_status;
                r_found  <= FOUND_NONE;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_status;
    assign o_out_value      = r_value;
    assign o_found_position = r_found;
    assign o_entry_count    = r_out_count;

    `OLE_ASSERT_IMPL(a_count_max, 1'b1, r_count <= CW'(DEPTH), "count above depth")
    `OLE_ASSERT_NEXT(a_count_upd, in_acc, r_count == $past(n_count), "count update")
    `OLE_ASSERT_IMPL(a_stall_full, r_s1_valid && r_out_valid && i_stall, o_stall, "overrun")
    `OLE_ASSERT_IMPL(a_miss, r_out_valid && r_status == ST_NOT_FOUND, &r_found, "miss position")

endmodule
